// ===== rtl/fvgd_pkg.sv =====
// Shared types and constants of the FAT volume geometry decoder.
package fvgd_pkg;

	localparam int unsigned DIV_W = 32;
	localparam int unsigned DIV_STEPS = 4;
	localparam int unsigned DIV_STAGES = DIV_W / DIV_STEPS;

	localparam logic [12:0] DEV_SECTOR_RESET = 13'd512;
	localparam logic [31:0] CLUS_FAT12_LIMIT = 32'd4085;
	localparam logic [31:0] CLUS_FAT16_LIMIT = 32'd65525;

	typedef enum logic [1:0] {
		ERR_OK,
		ERR_MISMATCH,
		ERR_NOT_FAT,
		ERR_GEOMETRY
	} err_t;

	typedef enum logic [1:0] {
		FAT12,
		FAT16,
		FAT32
	} fat_type_t;

	typedef struct packed {
		logic [15:0] bytes_per_sector;
		logic [7:0]  cluster_sectors;
		logic [15:0] reserved_sectors;
		logic [7:0]  fat_copies;
		logic [15:0] root_entries;
		logic [15:0] total_sectors_short;
		logic [31:0] total_sectors_long;
		logic [15:0] fat_size_short;
		logic [31:0] fat_size_long;
		logic [31:0] root_start_cluster;
	} in_beat_t;

	typedef struct packed {
		err_t        error_code;
		fat_type_t   fat_type;
		logic [31:0] fat_sectors;
		logic [31:0] total_sectors;
		logic [12:0] root_dir_sectors;
		logic [39:0] data_start_sector;
		logic [31:0] cluster_total;
		logic [31:0] root_cluster_out;
		logic [19:0] cluster_bytes;
		logic [14:0] dir_entries_per_cluster;
	} out_beat_t;

	// Geometry that rides alongside the cluster division
	typedef struct packed {
		err_t        err;
		logic [31:0] fat_sectors;
		logic [31:0] total_sectors;
		logic [12:0] root_dir_sectors;
		logic [39:0] data_start_sector;
		logic [19:0] cluster_bytes;
		logic [31:0] root_cluster;
	} side_t;

endpackage

// ===== rtl/fvgd_front.sv =====
// Front pipeline: boot record checks, FAT size, root directory and first data sector.
module fvgd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  fvgd_pkg::in_beat_t in_beat,
	input  logic [12:0]       dev_sector_size,
	output logic              vld_s4,
	output logic [31:0]       diff_s4,
	output logic [7:0]        spc_s4,
	output fvgd_pkg::side_t   side_s4
);

	logic              mismatch;
	logic              size_ok;
	logic              no_fat;
	logic [1:0]        shift_code;
	logic [11:0]       bps_m1;
	logic [21:0]       rds_sum;
	logic [4:0]        rds_shift;
	fvgd_pkg::side_t   side_d1;
	fvgd_pkg::side_t   side_d3;
	fvgd_pkg::side_t   side_d4;

	logic              vld_s1, vld_s2, vld_s3;
	fvgd_pkg::side_t   side_s1, side_s2, side_s3;
	logic [7:0]        spc_s1, spc_s2, spc_s3;
	logic [7:0]        copies_s1;
	logic [15:0]       rsv_s1;
	logic [39:0]       prod_s2;
	logic [16:0]       base_s2;
	logic              under;

	always_comb begin
		mismatch = (in_beat.bytes_per_sector != {3'b000, dev_sector_size});
		no_fat = (in_beat.fat_size_short == 16'd0) && (in_beat.fat_size_long == 32'd0);
		case (in_beat.bytes_per_sector)
			16'd512: begin
				size_ok = 1'b1;
				shift_code = 2'd0;
			end
			16'd1024: begin
				size_ok = 1'b1;
				shift_code = 2'd1;
			end
			16'd2048: begin
				size_ok = 1'b1;
				shift_code = 2'd2;
			end
			16'd4096: begin
				size_ok = 1'b1;
				shift_code = 2'd3;
			end
			default: begin
				size_ok = 1'b0;
				shift_code = 2'd0;
			end
		endcase

		if (mismatch) begin
			side_d1.err = fvgd_pkg::ERR_MISMATCH;
		end else if (!size_ok || no_fat) begin
			side_d1.err = fvgd_pkg::ERR_NOT_FAT;
		end else begin
			side_d1.err = fvgd_pkg::ERR_OK;
		end

		side_d1.fat_sectors = (in_beat.fat_size_short != 16'd0) ?
			{16'd0, in_beat.fat_size_short} : in_beat.fat_size_long;
		side_d1.total_sectors = ({16'd0, in_beat.total_sectors_short} >
			in_beat.total_sectors_long) ?
			{16'd0, in_beat.total_sectors_short} : in_beat.total_sectors_long;

		bps_m1 = 12'(in_beat.bytes_per_sector - 16'd1);
		rds_sum = {1'b0, in_beat.root_entries, 5'b00000} + {10'd0, bps_m1};
		rds_shift = 5'd9 + {3'b000, shift_code};
		side_d1.root_dir_sectors = 13'(rds_sum >> rds_shift);
		side_d1.data_start_sector = '0;
		side_d1.cluster_bytes = {3'b000, in_beat.cluster_sectors, 9'd0} << shift_code;
		side_d1.root_cluster = in_beat.root_start_cluster;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	assign under = (side_s3.data_start_sector > {8'd0, side_s3.total_sectors});

	always_comb begin
		side_d3 = side_s2;
		side_d3.data_start_sector = prod_s2 + {23'd0, base_s2};
		side_d4 = side_s3;
		if (side_s3.err == fvgd_pkg::ERR_OK && (spc_s3 == 8'd0 || under)) begin
			side_d4.err = fvgd_pkg::ERR_GEOMETRY;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1   <= side_d1;
			spc_s1    <= in_beat.cluster_sectors;
			copies_s1 <= in_beat.fat_copies;
			rsv_s1    <= in_beat.reserved_sectors;

			side_s2 <= side_s1;
			spc_s2  <= spc_s1;
			prod_s2 <= {32'd0, copies_s1} * {8'd0, side_s1.fat_sectors};
			base_s2 <= {1'b0, rsv_s1} + {4'd0, side_s1.root_dir_sectors};

			side_s3 <= side_d3;
			spc_s3  <= spc_s2;

			side_s4 <= side_d4;
			diff_s4 <= side_s3.total_sectors - side_s3.data_start_sector[31:0];
			spc_s4  <= spc_s3;
		end
	end

`ifndef SYNTHESIS
	a_mismatch_first: assert property (@(posedge clk) disable iff (!arst_n)
		en && in_valid && mismatch |=> side_s1.err == fvgd_pkg::ERR_MISMATCH)
		else $error("sector size mismatch not flagged");
	a_hold_s4: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s4) && $stable(diff_s4))
		else $error("front pipe moved while frozen");
	a_geom_err: assert property (@(posedge clk) disable iff (!arst_n)
		en && vld_s3 && side_s3.err == fvgd_pkg::ERR_OK && spc_s3 == 8'd0
		|=> side_s4.err == fvgd_pkg::ERR_GEOMETRY)
		else $error("zero cluster size not flagged");
`endif

endmodule

// ===== rtl/fvgd_div.sv =====
// Pipelined restoring divider for the cluster count, four quotient bits per stage.
module fvgd_div (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_vld,
	input  logic [31:0]     dividend,
	input  logic [7:0]      divisor,
	input  fvgd_pkg::side_t in_side,
	output logic            out_vld,
	output logic [31:0]     quotient,
	output fvgd_pkg::side_t out_side
);

	logic                  vld_s  [fvgd_pkg::DIV_STAGES];
	logic [31:0]           word_s [fvgd_pkg::DIV_STAGES];
	logic [7:0]            rem_s  [fvgd_pkg::DIV_STAGES];
	logic [7:0]            dvs_s  [fvgd_pkg::DIV_STAGES];
	fvgd_pkg::side_t       side_s [fvgd_pkg::DIV_STAGES];

	for (genvar g = 0; g < fvgd_pkg::DIV_STAGES; g++) begin : g_stage
		logic            vld_in;
		logic [31:0]     word_in;
		logic [7:0]      rem_in;
		logic [7:0]      dvs_in;
		fvgd_pkg::side_t side_in;
		logic [31:0]     w;
		logic [8:0]      r9;
		logic [7:0]      r;

		if (g == 0) begin : g_head
			assign vld_in  = in_vld;
			assign word_in = dividend;
			assign rem_in  = 8'd0;
			assign dvs_in  = divisor;
			assign side_in = in_side;
		end else begin : g_body
			assign vld_in  = vld_s[g-1];
			assign word_in = word_s[g-1];
			assign rem_in  = rem_s[g-1];
			assign dvs_in  = dvs_s[g-1];
			assign side_in = side_s[g-1];
		end

		// per step: shift in one dividend bit, subtract where it fits, shift in one quotient bit
		always_comb begin
			w = word_in;
			r = rem_in;
			r9 = '0;
			for (int j = 0; j < fvgd_pkg::DIV_STEPS; j++) begin
				r9 = {r, w[31]};
				w = {w[30:0], 1'b0};
				if (r9 >= {1'b0, dvs_in}) begin
					r9 = r9 - {1'b0, dvs_in};
					w[0] = 1'b1;
				end
				r = r9[7:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (en) begin
				vld_s[g] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				word_s[g] <= w;
				rem_s[g]  <= r;
				dvs_s[g]  <= dvs_in;
				side_s[g] <= side_in;
			end
		end
	end

	assign out_vld  = vld_s[fvgd_pkg::DIV_STAGES-1];
	assign quotient = word_s[fvgd_pkg::DIV_STAGES-1];
	assign out_side = side_s[fvgd_pkg::DIV_STAGES-1];

`ifndef SYNTHESIS
	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld && dvs_s[fvgd_pkg::DIV_STAGES-1] != 8'd0
		|-> rem_s[fvgd_pkg::DIV_STAGES-1] < dvs_s[fvgd_pkg::DIV_STAGES-1])
		else $error("division remainder not below divisor");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(out_vld) && $stable(quotient))
		else $error("divider moved while frozen");
	a_one_dvs: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld && dvs_s[fvgd_pkg::DIV_STAGES-1] == 8'd1
		|-> rem_s[fvgd_pkg::DIV_STAGES-1] == 8'd0)
		else $error("division by one left a remainder");
`endif

endmodule

// ===== rtl/fat_volume_geometry_decode.sv =====
// Top level of the FAT volume geometry decoder: register, pipelines and result register.
// Decodes the geometry of a FAT volume from one boot sector beat per cycle. A beat is
// accepted whenever in_valid is high and in_stall low; its result passes through four
// stages of checks and sector arithmetic, eight stages of the cluster-count divider at
// four quotient bits each and one result register on its way to out_beat. The whole
// pipeline freezes while a result waits on out_stall, so a new beat is taken every cycle
// the result side keeps up. cfg_wr_data sets the device sector size (512 after reset);
// the user must write it only while the block holds no beat, which it does not enforce.
module fat_volume_geometry_decode (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [12:0]         cfg_wr_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  fvgd_pkg::in_beat_t  in_beat,
	output logic                out_valid,
	input  logic                out_stall,
	output fvgd_pkg::out_beat_t out_beat
);

	logic [12:0]         dev_size_q;
	logic                en;
	logic                vld_s4;
	logic [31:0]         diff_s4;
	logic [7:0]          spc_s4;
	fvgd_pkg::side_t     side_s4;
	logic                div_vld;
	logic [31:0]         quot;
	fvgd_pkg::side_t     div_side;
	fvgd_pkg::out_beat_t res;
	logic                out_valid_q;
	fvgd_pkg::out_beat_t out_beat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_size_q <= fvgd_pkg::DEV_SECTOR_RESET;
		end else if (cfg_wr_en) begin
			dev_size_q <= cfg_wr_data;
		end
	end

	assign en = !(out_valid_q && out_stall);
	assign in_stall = !en;

	fvgd_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.en              (en),
		.in_valid        (in_valid),
		.in_beat         (in_beat),
		.dev_sector_size (dev_size_q),
		.vld_s4          (vld_s4),
		.diff_s4         (diff_s4),
		.spc_s4          (spc_s4),
		.side_s4         (side_s4)
	);

	fvgd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s4),
		.dividend (diff_s4),
		.divisor  (spc_s4),
		.in_side  (side_s4),
		.out_vld  (div_vld),
		.quotient (quot),
		.out_side (div_side)
	);

	always_comb begin
		res = '0;
		res.error_code = div_side.err;
		if (div_side.err == fvgd_pkg::ERR_OK || div_side.err == fvgd_pkg::ERR_GEOMETRY) begin
			res.fat_sectors = div_side.fat_sectors;
			res.total_sectors = div_side.total_sectors;
			res.root_dir_sectors = div_side.root_dir_sectors;
			res.data_start_sector = div_side.data_start_sector;
			res.cluster_bytes = div_side.cluster_bytes;
			res.dir_entries_per_cluster = div_side.cluster_bytes[19:5];
		end
		if (div_side.err == fvgd_pkg::ERR_OK) begin
			res.cluster_total = quot;
			if (quot < fvgd_pkg::CLUS_FAT12_LIMIT) begin
				res.fat_type = fvgd_pkg::FAT12;
			end else if (quot < fvgd_pkg::CLUS_FAT16_LIMIT) begin
				res.fat_type = fvgd_pkg::FAT16;
			end else begin
				res.fat_type = fvgd_pkg::FAT32;
				res.root_cluster_out = div_side.root_cluster;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= div_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en && div_vld) begin
			out_beat_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_beat  = out_beat_q;

`ifndef SYNTHESIS
	a_err_no_clusters: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_beat.error_code != fvgd_pkg::ERR_OK
		|-> out_beat.cluster_total == 32'd0 && out_beat.root_cluster_out == 32'd0)
		else $error("cluster fields set on an error beat");
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_beat.error_code == fvgd_pkg::ERR_MISMATCH ||
		out_beat.error_code == fvgd_pkg::ERR_NOT_FAT)
		|-> out_beat.fat_sectors == 32'd0 && out_beat.data_start_sector == 40'd0 &&
		out_beat.cluster_bytes == 20'd0)
		else $error("geometry set on a rejected boot record");
	a_root_fat32: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_beat.fat_type != fvgd_pkg::FAT32
		|-> out_beat.root_cluster_out == 32'd0)
		else $error("root cluster set on a FAT12 or FAT16 beat");
	a_cfg_taken: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr_en |=> dev_size_q == $past(cfg_wr_data))
		else $error("device sector size write lost");
`endif

endmodule
